@@ src/ppc_pkg.sv @@
// Shared types, constants and color ramp builders for the phosphor pixel composer.
package ppc_pkg;

    localparam int FRAME_SIDE = 1024;
    localparam int ADDR_W     = 2 * $clog2(FRAME_SIDE);
    localparam int LEVEL_W    = 8;
    localparam int DIV_W      = 10;
    localparam int CFG_DATA_W = 10;
    localparam int ROM_DEPTH  = 256;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

    // Reset values of the configuration registers.
    localparam logic [LEVEL_W-1:0] SUSTAIN_MIN_RST   = 8'd6;
    localparam logic [LEVEL_W-1:0] FULL_TRANSFER_RST = 8'd135;
    localparam logic [DIV_W-1:0]   TRANSFER_DIV_RST  = 10'd231;
    localparam logic [LEVEL_W-1:0] HALO_MIN_RST      = 8'd28;

    // Transfer divider: a 16-bit fraction, four quotient bits per stage.
    localparam int QUO_W       = 16;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_STAGES  = QUO_W / DIV_STEPS;
    localparam logic [QUO_W:0] QUO_ONE = 17'h10000;

    // Blend weight c = m * 65536 / 65025 is split as m + m * 511 / 65025.
    // The second term uses an exact reciprocal for dividends below 2^25.
    localparam int  BLEND_M_W      = 16;
    localparam int  BLEND_X_W      = 25;
    localparam int  BLEND_C_W      = 17;
    localparam int  BLEND_SHIFT    = 41;
    localparam int  BLEND_RECIP_W  = 26;
    localparam int  BLEND_P_W      = BLEND_X_W + BLEND_RECIP_W;
    localparam logic [63:0] BLEND_DIV = 64'd65025;
    localparam logic [BLEND_RECIP_W-1:0] BLEND_RECIP =
        BLEND_RECIP_W'(((64'd1 << BLEND_SHIFT) + BLEND_DIV - 64'd1) / BLEND_DIV);
    localparam logic [BLEND_C_W-1:0] BLEND_C_MAX = 17'h10000;

    // Ramp construction constants.
    localparam int unsigned GLOW_KNEE     = 35;
    localparam int unsigned GLOW_ALPHA_LO = 28;
    localparam logic [63:0] GLOW_SPAN_SQ  = 64'd48400;
    localparam logic [63:0] RAMP_SPAN     = 64'd255;
    localparam logic [63:0] Q30_ONE       = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] TRACE_PEAK    = 64'd169;
    localparam int unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};

    typedef enum logic [1:0] {
        CFG_SUSTAIN_MIN   = 2'd0,
        CFG_FULL_TRANSFER = 2'd1,
        CFG_TRANSFER_DIV  = 2'd2,
        CFG_HALO_MIN      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] sustain_min;
        logic [LEVEL_W-1:0] full_transfer_level;
        logic [DIV_W-1:0]   transfer_divisor;
        logic [LEVEL_W-1:0] halo_min;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [LEVEL_W-1:0] glow_level;
        logic [LEVEL_W-1:0] trace_level;
    } t_pix_in;

    typedef struct packed {
        logic [ADDR_W-1:0]  out_address;
        logic [LEVEL_W-1:0] trace_next;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] alpha;
        logic               trace_started;
        logic               clear_pixel;
    } t_pix_out;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] alpha;
    } t_rgba;

    // Item context carried alongside the transfer divider.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [LEVEL_W-1:0] glow;
        logic [LEVEL_W-1:0] trace;
        logic               ge_sustain;
        logic               ge_full;
        logic               div_live;
    } t_xctx;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div;

    // Result of the trace update, handed to the ramp lookup.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [LEVEL_W-1:0] glow;
        logic [LEVEL_W-1:0] trace_next;
        logic               started;
        logic               clear;
    } t_xfer;

    // Trace update plus both ramp colors, handed to the blender.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [LEVEL_W-1:0] glow;
        logic [LEVEL_W-1:0] trace_next;
        logic               started;
        logic               clear;
        logic               glow_only;
        logic [LEVEL_W-1:0] alpha_glow;
        t_rgba              gcol;
        t_rgba              pcol;
    } t_ramp;

    function automatic logic [LEVEL_W-1:0] glow_mix(input logic [63:0] blur,
                                                    input logic [63:0] bright,
                                                    input logic [63:0] n);
        return LEVEL_W'((blur * (GLOW_SPAN_SQ - n) + bright * n) / GLOW_SPAN_SQ);
    endfunction

    function automatic t_rgba glow_entry(input int unsigned idx);
        t_rgba       e;
        logic [63:0] j;
        logic [63:0] n;
        if (idx < GLOW_KNEE) begin
            e.red   = 8'h00;
            e.green = 8'h63;
            e.blue  = 8'heb;
            e.alpha = (idx < GLOW_ALPHA_LO) ? LEVEL_W'(GLOW_ALPHA_LO) : LEVEL_W'(idx);
        end else begin
            j = 64'(idx - GLOW_KNEE);
            n = j * j;
            e.red   = glow_mix(64'h00, 64'h3d, n);
            e.green = glow_mix(64'h63, 64'haa, n);
            e.blue  = glow_mix(64'heb, 64'hf7, n);
            e.alpha = LEVEL_W'(idx);
        end
        return e;
    endfunction

    // Squared sine of the ramp angle in Q30, from a Horner form of the series.
    function automatic logic [63:0] sin_sq_q30(input int unsigned idx);
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] t;
        logic [63:0] s;
        int          k;
        y  = (HALF_PI_Q30 * 64'(idx)) / RAMP_SPAN;
        y2 = (y * y) >> 30;
        t  = Q30_ONE;
        for (k = 0; k < 5; k++) begin
            t = Q30_ONE - (((y2 * t) >> 30) / 64'(TAYLOR_DIV[k]));
        end
        s = (y * t) >> 30;
        return (s * s) >> 30;
    endfunction

    function automatic logic [LEVEL_W-1:0] trace_mix(input logic [63:0] fresh,
                                                     input logic [63:0] aged,
                                                     input int unsigned idx);
        return LEVEL_W'((fresh * 64'(idx) + aged * (RAMP_SPAN - 64'(idx))) / RAMP_SPAN);
    endfunction

    function automatic t_rgba trace_entry(input int unsigned idx);
        t_rgba       e;
        logic [63:0] cq;
        logic [63:0] sum;
        logic [63:0] a;
        e.red   = trace_mix(64'd109, 64'd122, idx);
        e.green = trace_mix(64'd184, 64'd181, idx);
        e.blue  = trace_mix(64'd55, 64'd29, idx);
        cq  = (64'(idx) << 30) / RAMP_SPAN;
        sum = cq + sin_sq_q30(idx) + (64'd1 << 10);
        a   = (TRACE_PEAK * sum) >> 31;
        e.alpha = (a > 64'd255) ? LEVEL_MAX : LEVEL_W'(a);
        return e;
    endfunction

endpackage

@@ src/ppc_xfer.sv @@
// Trace transfer: flag stage, pipelined fraction divider and trace update stage.
module ppc_xfer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppc_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  ppc_pkg::t_pix_in i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ppc_pkg::t_xfer  o_data
);
    import ppc_pkg::*;

    function automatic t_div div_steps(input t_div din, input logic [DIV_W-1:0] dvs);
        t_div         acc;
        logic [DIV_W:0] r2;
        int           k;
        acc = din;
        for (k = 0; k < DIV_STEPS; k++) begin
            r2 = {acc.rem, 1'b0};
            if (r2 >= {1'b0, dvs}) begin
                acc.rem = DIV_W'(r2 - {1'b0, dvs});
                acc.quo = {acc.quo[QUO_W-2:0], 1'b1};
            end else begin
                acc.rem = r2[DIV_W-1:0];
                acc.quo = {acc.quo[QUO_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // Flag stage.
    logic              r_a_vld;
    t_xctx             r_a_ctx;
    logic [DIV_W-1:0]  r_a_rem;
    t_xctx             n_a_ctx;
    logic [DIV_W-1:0]  n_a_rem;
    logic              rdy_a;

    // Divider stages.
    logic              r_d_vld [DIV_STAGES];
    t_xctx             r_d_ctx [DIV_STAGES];
    t_div              r_d_div [DIV_STAGES];
    logic              src_vld [DIV_STAGES];
    t_xctx             src_ctx [DIV_STAGES];
    t_div              src_div [DIV_STAGES];
    logic              rdy_d   [DIV_STAGES+1];

    // Update stage.
    logic              r_f_vld;
    t_xfer             r_f_out;
    t_xfer             n_f_out;
    logic              rdy_f;
    t_xctx             f_ctx;
    logic [QUO_W:0]    f_frac;
    logic [BLEND_X_W-1:0] f_scaled;
    logic [LEVEL_W-1:0] f_u;

    assign rdy_f   = !r_f_vld || !i_stall;
    assign rdy_d[DIV_STAGES] = rdy_f;
    assign rdy_a   = !r_a_vld || rdy_d[0];
    assign o_stall = !rdy_a;

    always_comb begin
        n_a_ctx.address    = i_data.pixel_address;
        n_a_ctx.glow       = i_data.glow_level;
        n_a_ctx.trace      = i_data.trace_level;
        n_a_ctx.ge_sustain = i_data.glow_level >= i_cfg.sustain_min;
        n_a_ctx.ge_full    = i_data.glow_level >= i_cfg.full_transfer_level;
        // Only meaningful below full transfer level; the quotient stays under
        // one exactly when the shortfall is below the divisor.
        n_a_rem = DIV_W'(LEVEL_W'(i_cfg.full_transfer_level - i_data.glow_level));
        n_a_ctx.div_live   = n_a_rem < i_cfg.transfer_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (rdy_a) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_ctx <= n_a_ctx;
            r_a_rem <= n_a_rem;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        if (k == 0) begin : g_first
            assign src_vld[k]     = r_a_vld;
            assign src_ctx[k]     = r_a_ctx;
            assign src_div[k].rem = r_a_rem;
            assign src_div[k].quo = '0;
        end else begin : g_next
            assign src_vld[k] = r_d_vld[k-1];
            assign src_ctx[k] = r_d_ctx[k-1];
            assign src_div[k] = r_d_div[k-1];
        end

        assign rdy_d[k] = !r_d_vld[k] || rdy_d[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k] <= 1'b0;
            end else if (rdy_d[k]) begin
                r_d_vld[k] <= src_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy_d[k]) begin
                r_d_ctx[k] <= src_ctx[k];
                r_d_div[k] <= div_steps(src_div[k], i_cfg.transfer_divisor);
            end
        end
    end

    always_comb begin
        f_ctx    = r_d_ctx[DIV_STAGES-1];
        f_frac   = QUO_ONE - {1'b0, r_d_div[DIV_STAGES-1].quo};
        f_scaled = {f_frac, 8'b0} - BLEND_X_W'(f_frac);
        if (f_ctx.ge_full) begin
            f_u = LEVEL_MAX;
        end else if (f_ctx.div_live) begin
            f_u = f_scaled[23:16];
        end else begin
            f_u = '0;
        end
        n_f_out.address = f_ctx.address;
        n_f_out.glow    = f_ctx.glow;
        if (f_ctx.ge_sustain && (f_u > f_ctx.trace)) begin
            n_f_out.trace_next = f_u;
        end else begin
            n_f_out.trace_next = f_ctx.trace;
        end
        n_f_out.started = f_ctx.ge_sustain && (f_ctx.trace == '0);
        n_f_out.clear   = !f_ctx.ge_sustain && (f_ctx.trace == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (rdy_f) begin
            r_f_vld <= r_d_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_f) begin
            r_f_out <= n_f_out;
        end
    end

    assign o_valid = r_f_vld;
    assign o_data  = r_f_out;

    a_start_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld |-> !(r_f_out.started && r_f_out.clear))
        else $error("trace start and clear flagged together");

    a_clear_no_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_vld && r_f_out.clear) |-> (r_f_out.trace_next == '0))
        else $error("cleared pixel carries a trace");

endmodule

@@ src/ppc_ramp.sv @@
// Ramp lookup stage: glow and trace colors from the constant ramps.
module ppc_ramp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppc_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  ppc_pkg::t_xfer  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output ppc_pkg::t_ramp  o_data
);
    import ppc_pkg::*;

    t_rgba glow_rom  [ROM_DEPTH];
    t_rgba trace_rom [ROM_DEPTH];

    logic  r_vld;
    t_ramp r_out;
    t_ramp n_out;
    logic  rdy;

    for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
        assign glow_rom[i]  = glow_entry(i);
        assign trace_rom[i] = trace_entry(i);
    end

    assign rdy     = !r_vld || !i_stall;
    assign o_stall = !rdy;

    always_comb begin
        n_out.address    = i_data.address;
        n_out.glow       = i_data.glow;
        n_out.trace_next = i_data.trace_next;
        n_out.started    = i_data.started;
        n_out.clear      = i_data.clear;
        n_out.gcol       = glow_rom[i_data.glow];
        n_out.pcol       = trace_rom[i_data.trace_next];
        n_out.glow_only  = (i_data.trace_next == '0) || (i_data.glow == LEVEL_MAX);
        if ((i_data.trace_next == '0) && (i_data.glow < i_cfg.halo_min)) begin
            n_out.alpha_glow = i_cfg.halo_min;
        end else begin
            n_out.alpha_glow = i_data.glow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_out;

endmodule

@@ src/ppc_blend.sv @@
// Color blend: weight product, weight scaling and per-channel mix with saturation.
module ppc_blend (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ppc_pkg::t_ramp    i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output ppc_pkg::t_pix_out o_data
);
    import ppc_pkg::*;

    function automatic logic [LEVEL_W-1:0] mix_ch(input logic [LEVEL_W-1:0] gc,
                                                  input logic [LEVEL_W-1:0] pc,
                                                  input logic [BLEND_C_W-1:0] c);
        logic [9:0]  base;
        logic [26:0] acc;
        logic [9:0]  v;
        base = {1'b0, gc, 1'b0} + {2'b0, pc};
        acc  = {1'b0, base, 16'b0} + (27'(pc) * 27'(c));
        v    = acc[26:17];
        return (v > 10'(LEVEL_MAX)) ? LEVEL_MAX : v[LEVEL_W-1:0];
    endfunction

    logic                  r_b1_vld;
    t_ramp                 r_b1;
    logic [BLEND_M_W-1:0]  r_b1_m;
    logic                  r_b2_vld;
    t_ramp                 r_b2;
    logic [BLEND_C_W-1:0]  r_b2_c;
    logic                  r_b3_vld;
    t_pix_out              r_b3_out;

    logic                  rdy1;
    logic                  rdy2;
    logic                  rdy3;
    logic [BLEND_M_W-1:0]  n_m;
    logic [BLEND_X_W-1:0]  n_x;
    logic [BLEND_P_W-1:0]  n_prod;
    logic [BLEND_C_W-1:0]  n_c;
    logic [LEVEL_W:0]      n_asum;
    t_pix_out              n_out;

    assign rdy3    = !r_b3_vld || !i_stall;
    assign rdy2    = !r_b2_vld || rdy3;
    assign rdy1    = !r_b1_vld || rdy2;
    assign o_stall = !rdy1;

    assign n_m = BLEND_M_W'(i_data.pcol.alpha) * BLEND_M_W'(LEVEL_MAX - i_data.glow);

    // c = m + floor(m * 511 / 65025), the quotient taken by reciprocal.
    always_comb begin
        n_x    = {r_b1_m, 9'b0} - BLEND_X_W'(r_b1_m);
        n_prod = BLEND_P_W'(n_x) * BLEND_P_W'(BLEND_RECIP);
        n_c    = BLEND_C_W'(r_b1_m) + BLEND_C_W'(n_prod[BLEND_P_W-1:BLEND_SHIFT]);
    end

    always_comb begin
        n_asum = {1'b0, r_b2.glow} + {1'b0, r_b2.pcol.alpha};
        n_out.out_address   = r_b2.address;
        n_out.trace_next    = r_b2.trace_next;
        n_out.trace_started = r_b2.started;
        n_out.clear_pixel   = r_b2.clear;
        if (r_b2.glow_only) begin
            n_out.red   = r_b2.gcol.red;
            n_out.green = r_b2.gcol.green;
            n_out.blue  = r_b2.gcol.blue;
            n_out.alpha = r_b2.alpha_glow;
        end else begin
            n_out.red   = mix_ch(r_b2.gcol.red, r_b2.pcol.red, r_b2_c);
            n_out.green = mix_ch(r_b2.gcol.green, r_b2.pcol.green, r_b2_c);
            n_out.blue  = mix_ch(r_b2.gcol.blue, r_b2.pcol.blue, r_b2_c);
            n_out.alpha = n_asum[LEVEL_W] ? LEVEL_MAX : n_asum[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
        end else begin
            if (rdy1) begin
                r_b1_vld <= i_valid;
            end
            if (rdy2) begin
                r_b2_vld <= r_b1_vld;
            end
            if (rdy3) begin
                r_b3_vld <= r_b2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_b1   <= i_data;
            r_b1_m <= n_m;
        end
        if (rdy2) begin
            r_b2   <= r_b1;
            r_b2_c <= n_c;
        end
        if (rdy3) begin
            r_b3_out <= n_out;
        end
    end

    assign o_valid = r_b3_vld;
    assign o_data  = r_b3_out;

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_vld |-> (r_b2_c <= BLEND_C_MAX))
        else $error("blend weight above one");

endmodule

@@ src/phosphor_pixel_compose.sv @@
// Top level of the phosphor pixel composer: configuration registers and the pipeline.
// Throughput: one pixel per clock when not stalled; the fraction divider spans four stages.
// Stalls collapse bubbles stage by stage, so input is taken while a result waits.
// Synchronous active-low reset clears all stage valid bits and loads the register defaults.
// The color ramps are constant logic and need no initialization after reset.
module phosphor_pixel_compose (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  ppc_pkg::t_pix_in       i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ppc_pkg::t_pix_out      o_out_data,
    input  logic                   i_cfg_we,
    input  ppc_pkg::t_cfg_idx      i_cfg_idx,
    input  logic [ppc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ppc_pkg::*;

    t_cfg  r_cfg;

    logic  xf_valid;
    logic  xf_stall;
    t_xfer xf_data;
    logic  rp_valid;
    logic  rp_stall;
    t_ramp rp_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sustain_min         <= SUSTAIN_MIN_RST;
            r_cfg.full_transfer_level <= FULL_TRANSFER_RST;
            r_cfg.transfer_divisor    <= TRANSFER_DIV_RST;
            r_cfg.halo_min            <= HALO_MIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SUSTAIN_MIN:   r_cfg.sustain_min <= i_cfg_data[LEVEL_W-1:0];
                CFG_FULL_TRANSFER: r_cfg.full_transfer_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_TRANSFER_DIV:  r_cfg.transfer_divisor <= i_cfg_data[DIV_W-1:0];
                CFG_HALO_MIN:      r_cfg.halo_min <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppc_xfer u_xfer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_valid (xf_valid),
        .i_stall (xf_stall),
        .o_data  (xf_data)
    );

    ppc_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (xf_valid),
        .o_stall (xf_stall),
        .i_data  (xf_data),
        .o_valid (rp_valid),
        .i_stall (rp_stall),
        .o_data  (rp_data)
    );

    ppc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rp_valid),
        .o_stall (rp_stall),
        .i_data  (rp_data),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

    // With nothing waiting at the output every stage can move, so input must flow.
    a_in_open_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output register is empty");

endmodule
